/* rtl/viahdr_pkg.sv */
// ----------------------------------------------------------------------------
// viahdr_pkg
// Shared types, character codes and classifier functions for the Via header
// value validator.
// ----------------------------------------------------------------------------
`default_nettype none

package viahdr_pkg;

    localparam int unsigned LEN_W        = 11;
    localparam int unsigned NEST_W       = 4;
    localparam int unsigned MAX_LINE_DEF = 1024;

    localparam logic [NEST_W-1:0] NEST_RESET = 4'd5;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_ASCII_MAX = 8'h7F;

    typedef enum logic [2:0] {
        PH_LEAD    = 3'd0,
        PH_FIRST   = 3'd1,
        PH_GAP1    = 3'd2,
        PH_HOST    = 3'd3,
        PH_GAP2    = 3'd4,
        PH_COMMENT = 3'd5,
        PH_TAIL    = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } via_in_t;

    typedef struct packed {
        logic             valid_res;
        logic [LEN_W-1:0] name_length;
        logic [LEN_W-1:0] version_length;
        logic [LEN_W-1:0] host_length;
        logic [LEN_W-1:0] comment_length;
        logic             too_long;
    } via_out_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    // HTTP token character: alphanumerics plus !#$%&'*+-.^_`|~
    function automatic logic is_tok(input logic [7:0] b);
        logic r;
        case (b) inside
            [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]:   r = 1'b1;
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
            8'h2A, 8'h2B, 8'h2D, 8'h2E, 8'h5E, 8'h5F,
            8'h60, 8'h7C, 8'h7E:                          r = 1'b1;
            default:                                      r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/http_via_header_validator_top.sv */
// ----------------------------------------------------------------------------
// http_via_header_validator_top
// Byte-streaming validator for one HTTP Via entry: [name/]version host
// [comment]. Reports validity and field lengths on the last byte.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_ready    via_in_t  (byte_value, last_byte)
//  out       source     out_valid / out_ready  via_out_t (flags and lengths)
//  cfg       sink       cfg_wr_en              cfg_wr_data (max_nesting)
//
//  One byte per cycle: the parse state updates in the cycle a request is taken.
//  A last byte loads the result register; it shows in the cycle after acceptance.
//  in_ready drops only while a result waits and out_ready is low.
//  Reset clears the parse state and sets max_nesting to 5.
// ----------------------------------------------------------------------------
`default_nettype none

module http_via_header_validator_top
    import viahdr_pkg::*;
#(
    parameter int unsigned MAX_LINE = MAX_LINE_DEF
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire via_in_t           in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output via_out_t               out_data,
    input  wire logic              cfg_wr_en,
    input  wire logic [NEST_W-1:0] cfg_wr_data
);

    localparam int unsigned CNT_W = $clog2(MAX_LINE + 1);
    localparam int unsigned TOT_W = $clog2(MAX_LINE + 2);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LINE);
    localparam logic [TOT_W-1:0] TOT_MAX = TOT_W'(MAX_LINE);

    logic [NEST_W-1:0] max_nesting_reg;

    phase_t            phase_reg,          phase_next;
    logic              failed_reg,         failed_next;
    logic              saw_slash_reg,      saw_slash_next;
    logic              escape_reg,         escape_next;
    logic [NEST_W-1:0] nest_reg,           nest_next;
    logic [TOT_W-1:0]  total_reg,          total_next;
    logic [CNT_W-1:0]  name_cnt_reg,       name_cnt_next;
    logic [CNT_W-1:0]  version_cnt_reg,    version_cnt_next;
    logic [CNT_W-1:0]  host_cnt_reg,       host_cnt_next;
    logic [CNT_W-1:0]  comment_cnt_reg,    comment_cnt_next;

    logic              out_valid_reg;
    via_out_t          out_data_reg,       out_data_next;

    logic              in_fire;
    logic [7:0]        b;
    logic              b_ws;
    logic              run_first;
    logic              run_host;
    logic              run_open;
    logic [NEST_W:0]   open_depth;
    logic [NEST_W-1:0] close_depth;
    logic              ok;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign b        = in_data.byte_value;
    assign b_ws     = is_ws(b);

    // ------------------------------------------------------------------
    // Next parse state
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next       = phase_reg;
        failed_next      = failed_reg;
        saw_slash_next   = saw_slash_reg;
        escape_next      = escape_reg;
        nest_next        = nest_reg;
        name_cnt_next    = name_cnt_reg;
        version_cnt_next = version_cnt_reg;
        host_cnt_next    = host_cnt_reg;
        comment_cnt_next = comment_cnt_reg;
        run_first        = 1'b0;
        run_host         = 1'b0;
        run_open         = 1'b0;
        open_depth       = {1'b0, nest_reg} + 1'b1;
        close_depth      = (nest_reg != '0) ? nest_reg - 1'b1 : nest_reg;

        // total counts one past the limit so too_long can be seen
        total_next = (total_reg <= TOT_MAX) ? total_reg + 1'b1 : total_reg;

        if (!failed_reg)
        begin
            unique case (phase_reg)
                PH_LEAD:
                begin
                    if (!b_ws)
                    begin
                        phase_next = PH_FIRST;
                        run_first  = 1'b1;
                    end
                end
                PH_FIRST:
                    run_first = 1'b1;
                PH_GAP1:
                begin
                    if (!b_ws)
                    begin
                        phase_next = PH_HOST;
                        run_host   = 1'b1;
                    end
                end
                PH_HOST:
                    run_host = 1'b1;
                PH_GAP2:
                begin
                    if (!b_ws)
                    begin
                        if (b != CH_LPAREN)
                            failed_next = 1'b1;
                        else
                        begin
                            phase_next = PH_COMMENT;
                            if (comment_cnt_reg < CNT_MAX)
                                comment_cnt_next = comment_cnt_reg + 1'b1;
                            run_open = 1'b1;
                        end
                    end
                end
                PH_COMMENT:
                begin
                    if (comment_cnt_reg < CNT_MAX)
                        comment_cnt_next = comment_cnt_reg + 1'b1;
                    if (escape_reg)
                    begin
                        escape_next = 1'b0;
                        if (b > CH_ASCII_MAX || b == CH_CR || b == CH_LF || b == CH_NUL)
                            failed_next = 1'b1;
                    end
                    else if (b == CH_BSLASH)
                        escape_next = 1'b1;
                    else if (b == CH_LPAREN)
                        run_open = 1'b1;
                    else if (b == CH_RPAREN)
                    begin
                        nest_next = close_depth;
                        if (close_depth == '0)
                            phase_next = PH_TAIL;
                    end
                    else if (b < CH_SPACE && b != CH_TAB)
                        failed_next = 1'b1;
                end
                PH_TAIL:
                begin
                    if (!b_ws)
                        failed_next = 1'b1;
                end
                default:
                    failed_next = 1'b1;
            endcase

            if (run_first)
            begin
                if (b_ws)
                begin
                    if (version_cnt_reg == '0)
                        failed_next = 1'b1;
                    phase_next = PH_GAP1;
                end
                else if (b == CH_SLASH)
                begin
                    if (saw_slash_reg || version_cnt_reg == '0)
                        failed_next = 1'b1;
                    else
                    begin
                        saw_slash_next   = 1'b1;
                        name_cnt_next    = version_cnt_reg;
                        version_cnt_next = '0;
                    end
                end
                else if (is_tok(b))
                begin
                    if (version_cnt_reg < CNT_MAX)
                        version_cnt_next = version_cnt_reg + 1'b1;
                end
                else
                    failed_next = 1'b1;
            end

            if (run_host)
            begin
                if (b_ws)
                    phase_next = PH_GAP2;
                else if (b == CH_CR || b == CH_SLASH || b == CH_COMMA)
                    failed_next = 1'b1;
                else if (host_cnt_reg < CNT_MAX)
                    host_cnt_next = host_cnt_reg + 1'b1;
            end

            if (run_open)
            begin
                if (open_depth > {1'b0, max_nesting_reg})
                    failed_next = 1'b1;
                else
                    nest_next = open_depth[NEST_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result word
    // ------------------------------------------------------------------
    always_comb
    begin
        ok = !failed_next &&
             (phase_next == PH_HOST || phase_next == PH_GAP2 || phase_next == PH_TAIL);
        out_data_next.valid_res      = ok;
        out_data_next.name_length    = ok ? LEN_W'(name_cnt_next)    : '0;
        out_data_next.version_length = ok ? LEN_W'(version_cnt_next) : '0;
        out_data_next.host_length    = ok ? LEN_W'(host_cnt_next)    : '0;
        out_data_next.comment_length = ok ? LEN_W'(comment_cnt_next) : '0;
        out_data_next.too_long       = (total_next > TOT_MAX);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_nesting_reg <= NEST_RESET;
        else if (cfg_wr_en)
            max_nesting_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LEAD;
            failed_reg      <= 1'b0;
            saw_slash_reg   <= 1'b0;
            escape_reg      <= 1'b0;
            nest_reg        <= '0;
            total_reg       <= '0;
            name_cnt_reg    <= '0;
            version_cnt_reg <= '0;
            host_cnt_reg    <= '0;
            comment_cnt_reg <= '0;
        end
        else if (in_fire)
        begin
            if (in_data.last_byte)
            begin
                phase_reg       <= PH_LEAD;
                failed_reg      <= 1'b0;
                saw_slash_reg   <= 1'b0;
                escape_reg      <= 1'b0;
                nest_reg        <= '0;
                total_reg       <= '0;
                name_cnt_reg    <= '0;
                version_cnt_reg <= '0;
                host_cnt_reg    <= '0;
                comment_cnt_reg <= '0;
            end
            else
            begin
                phase_reg       <= phase_next;
                failed_reg      <= failed_next;
                saw_slash_reg   <= saw_slash_next;
                escape_reg      <= escape_next;
                nest_reg        <= nest_next;
                total_reg       <= total_next;
                name_cnt_reg    <= name_cnt_next;
                version_cnt_reg <= version_cnt_next;
                host_cnt_reg    <= host_cnt_next;
                comment_cnt_reg <= comment_cnt_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire && in_data.last_byte)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_data.last_byte)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_invalid_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.valid_res) |->
            (out_data.name_length == '0 && out_data.version_length == '0 &&
             out_data.host_length == '0 && out_data.comment_length == '0))
        else $error("invalid result carries nonzero lengths");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.last_byte) |=>
            (phase_reg == PH_LEAD && total_reg == '0 && !failed_reg))
        else $error("parse state not cleared after last byte");

    a_nest_outside_comment: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_COMMENT) |-> (nest_reg == '0))
        else $error("nesting depth nonzero outside comment");

    a_result_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.last_byte) |=> out_valid)
        else $error("last byte did not produce a result");

endmodule

`default_nettype wire
